// ===== hw/rtl/sps_pkg.sv =====
// Shared constants, types and the CORDIC angle table of the scan point segmenter.
`timescale 1ns / 1ps

package sps_pkg;

    localparam int MAX_SEGMENTS = 1024;
    localparam int CORDIC_STEPS = 16;
    localparam int STEP_W       = $clog2(CORDIC_STEPS);
    localparam int SEG_LIMIT    = (MAX_SEGMENTS - 1 > 1023) ? 1023 : MAX_SEGMENTS - 1;

    localparam logic [15:0] QUARTER_TURN    = 16'h4000;
    localparam logic [15:0] ANGLE_STEP_RST  = 16'd91;
    localparam logic [15:0] BREAK_DIST_RST  = 16'd64;
    localparam logic signed [31:0] CORDIC_GAIN_INV = 32'sd652032874;
    localparam logic signed [20:0] COORD_LIMIT     = 21'sd65535;

    // register indexes (paddr[3:2])
    localparam logic [1:0] REG_ANGLE_START = 2'd0;
    localparam logic [1:0] REG_ANGLE_STEP  = 2'd1;
    localparam logic [1:0] REG_BREAK_DIST  = 2'd2;

    typedef struct packed {
        logic [15:0] angle_start;
        logic [15:0] angle_step;
        logic [15:0] break_mm;
        logic        beam_load;
        logic [15:0] beam_value;
    } sps_cfg_t;

    // atan(2^-i) in units of 2^-32 turn
    function automatic logic [31:0] atan_turn32(input logic [4:0] idx);
        logic [31:0] v;
        unique case (idx)
            5'd0:    v = 32'd536870912;
            5'd1:    v = 32'd316933406;
            5'd2:    v = 32'd167458907;
            5'd3:    v = 32'd85004756;
            5'd4:    v = 32'd42667331;
            5'd5:    v = 32'd21354465;
            5'd6:    v = 32'd10679838;
            5'd7:    v = 32'd5340245;
            5'd8:    v = 32'd2670163;
            5'd9:    v = 32'd1335087;
            5'd10:   v = 32'd667544;
            5'd11:   v = 32'd333772;
            5'd12:   v = 32'd166886;
            5'd13:   v = 32'd83443;
            5'd14:   v = 32'd41722;
            5'd15:   v = 32'd20861;
            5'd16:   v = 32'd10430;
            5'd17:   v = 32'd5215;
            5'd18:   v = 32'd2608;
            5'd19:   v = 32'd1304;
            5'd20:   v = 32'd652;
            5'd21:   v = 32'd326;
            5'd22:   v = 32'd163;
            5'd23:   v = 32'd81;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage

// ===== hw/rtl/sps_if.sv =====
// Handshake interfaces for the sample and point channels.
`timescale 1ns / 1ps

interface sps_sample_if import sps_pkg::*; ();
    logic        valid;
    logic        ready;
    logic [15:0] range_mm;
    logic        end_of_scan;

    modport source (output valid, range_mm, end_of_scan, input ready);
    modport sink   (input valid, range_mm, end_of_scan, output ready);
endinterface

interface sps_point_if import sps_pkg::*; ();
    logic               valid;
    logic               ready;
    logic signed [16:0] point_x;
    logic signed [16:0] point_y;
    logic [9:0]         segment_id;
    logic               point_valid;
    logic               scan_done;

    modport source (output valid, point_x, point_y, segment_id, point_valid, scan_done,
                    input ready);
    modport sink   (input valid, point_x, point_y, segment_id, point_valid, scan_done,
                    output ready);
endinterface

// ===== hw/rtl/sps_cfg.sv =====
// APB register block: angle start, angle step and break distance.
`timescale 1ns / 1ps

module sps_cfg import sps_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output sps_cfg_t    cfg
);

    logic [15:0] start_reg, start_next;
    logic [15:0] step_reg, step_next;
    logic [15:0] brk_reg, brk_next;
    logic        wr_en;
    logic [1:0]  idx;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;
    assign idx    = paddr[3:2];

    always_comb
    begin
        start_next = start_reg;
        step_next  = step_reg;
        brk_next   = brk_reg;
        if (wr_en)
        begin
            unique case (idx)
                REG_ANGLE_START: start_next = pwdata[15:0];
                REG_ANGLE_STEP:  step_next  = pwdata[15:0];
                REG_BREAK_DIST:  brk_next   = pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg <= '0;
            step_reg  <= ANGLE_STEP_RST;
            brk_reg   <= BREAK_DIST_RST;
        end
        else
        begin
            start_reg <= start_next;
            step_reg  <= step_next;
            brk_reg   <= brk_next;
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_ANGLE_START: prdata = {16'd0, start_reg};
            REG_ANGLE_STEP:  prdata = {16'd0, step_reg};
            REG_BREAK_DIST:  prdata = {16'd0, brk_reg};
            default:         prdata = '0;
        endcase
    end

    assign cfg.angle_start = start_reg;
    assign cfg.angle_step  = step_reg;
    assign cfg.break_mm    = brk_reg;
    assign cfg.beam_load   = wr_en && (idx == REG_ANGLE_START);
    assign cfg.beam_value  = pwdata[15:0];

endmodule

// ===== hw/rtl/sps_cordic.sv =====
// Iterative rotation-mode CORDIC: one micro-rotation per cycle, cos and sin of a 16-bit angle.
`timescale 1ns / 1ps

module sps_cordic import sps_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [15:0]        angle,
    output logic               done,
    output logic signed [31:0] cos_v,
    output logic signed [31:0] sin_v
);

    logic signed [31:0] x_reg, x_next;
    logic signed [31:0] y_reg, y_next;
    logic signed [31:0] z_reg, z_next;
    logic [STEP_W-1:0]  step_reg, step_next;
    logic               flip_reg, flip_next;
    logic               run_reg, run_next;
    logic               done_reg, done_next;

    logic signed [31:0] a32;
    logic signed [32:0] a_ext;
    logic signed [32:0] z_fold;
    logic               fold;
    logic signed [31:0] dx;
    logic signed [31:0] dy;
    logic signed [31:0] at;
    logic               last_step;

    always_comb
    begin
        a32   = {angle, 16'd0};
        a_ext = {a32[31], a32};
        fold  = 1'b1;
        // fold into a quarter turn either side of zero; negate at the end
        if (a_ext > 33'sh040000000)
            z_fold = a_ext - 33'sh080000000;
        else if (a_ext < -33'sh040000000)
            z_fold = a_ext + 33'sh080000000;
        else
        begin
            z_fold = a_ext;
            fold   = 1'b0;
        end
    end

    assign dx        = y_reg >>> step_reg;
    assign dy        = x_reg >>> step_reg;
    assign at        = signed'(atan_turn32(5'(step_reg)));
    assign last_step = (step_reg == STEP_W'(CORDIC_STEPS - 1));

    always_comb
    begin
        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;
        step_next = step_reg;
        flip_next = flip_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (start)
        begin
            x_next    = CORDIC_GAIN_INV;
            y_next    = '0;
            z_next    = z_fold[31:0];
            step_next = '0;
            flip_next = fold;
            run_next  = 1'b1;
        end
        else if (run_reg)
        begin
            if (!z_reg[31])
            begin
                x_next = x_reg - dx;
                y_next = y_reg + dy;
                z_next = z_reg - at;
            end
            else
            begin
                x_next = x_reg + dx;
                y_next = y_reg - dy;
                z_next = z_reg + at;
            end
            step_next = step_reg + 1'b1;
            if (last_step)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg    <= x_next;
        y_reg    <= y_next;
        z_reg    <= z_next;
        flip_reg <= flip_next;
    end

    assign done  = done_reg;
    assign cos_v = flip_reg ? -x_reg : x_reg;
    assign sin_v = flip_reg ? -y_reg : y_reg;

    a_done_after_run: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !run_reg)
        else $error("cordic done while still rotating");

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        run_reg |-> !start)
        else $error("cordic restarted mid-rotation");

    a_run_len: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(done_reg) |-> $past(last_step))
        else $error("cordic finished at wrong step");

endmodule

// ===== hw/rtl/sps_mul.sv =====
// Shared signed multiplier with registered product.
`timescale 1ns / 1ps

module sps_mul import sps_pkg::*;
(
    input  logic               clk,
    input  logic signed [18:0] a,
    input  logic signed [31:0] b,
    output logic signed [50:0] p
);

    logic signed [50:0] p_reg, p_next;

    assign p_next = 51'(a) * 51'(b);

    always_ff @(posedge clk)
    begin
        p_reg <= p_next;
    end

    assign p = p_reg;

endmodule

// ===== hw/rtl/scan_point_segmenter.sv =====
// Top level: sequencer around the CORDIC and the shared multiplier, segment tracking.
//
//  channel   dir   handshake      beat contents
//  sample    in    valid/ready    range_mm[15:0], end_of_scan
//  point     out   valid/ready    point_x[16:0], point_y[16:0], segment_id[9:0],
//                                 point_valid, scan_done
//  apb       in    psel/penable   paddr[3:0], pwdata[31:0] -> prdata[31:0]
//
// A sample with a return goes from accept through the CORDIC (16 micro-rotations),
// then one multiplier pass each for x, y, dx^2, dy^2 and break^2, compare and load
// before the next ready; the point is registered at the load step.
// A sample with no return is done at accept; a bare end-of-scan marker goes on to load.
// One sample at a time; sample.ready is low while one is in flight.
// A full output register holds the sequencer in its load step until point.ready.
// Reset is asynchronous; no clearing pass.
`timescale 1ns / 1ps

module scan_point_segmenter import sps_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    sps_sample_if.sink  sample,
    sps_point_if.source point,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    typedef enum logic [8:0] {
        ST_IDLE = 9'b000000001,
        ST_ROT  = 9'b000000010,
        ST_MX   = 9'b000000100,
        ST_MY   = 9'b000001000,
        ST_DX   = 9'b000010000,
        ST_DY   = 9'b000100000,
        ST_BD   = 9'b001000000,
        ST_CMP  = 9'b010000000,
        ST_OUT  = 9'b100000000
    } state_t;

    sps_cfg_t cfg;

    state_t             state_reg, state_next;
    logic [15:0]        range_reg, range_next;
    logic               eos_reg, eos_next;
    logic               pv_reg, pv_next;
    logic [15:0]        beam_reg, beam_next;
    logic signed [16:0] last_x_reg, last_x_next;
    logic signed [16:0] last_y_reg, last_y_next;
    logic               have_reg, have_next;
    logic [9:0]         seg_reg, seg_next;
    logic signed [16:0] px_reg, px_next;
    logic signed [16:0] py_reg, py_next;
    logic [35:0]        sq_reg, sq_next;
    logic               brk_reg, brk_next;

    logic               ov_reg, ov_next;
    logic signed [16:0] ox_reg, ox_next;
    logic signed [16:0] oy_reg, oy_next;
    logic [9:0]         oseg_reg, oseg_next;
    logic               opv_reg, opv_next;
    logic               odone_reg, odone_next;

    logic               accept;
    logic               cordic_start;
    logic               cordic_done;
    logic signed [31:0] cos_v;
    logic signed [31:0] sin_v;
    logic signed [18:0] mul_a;
    logic signed [31:0] mul_b;
    logic signed [50:0] prod;
    logic signed [17:0] dx;
    logic signed [17:0] dy;
    logic               out_load;
    logic [9:0]         seg_new;

    // round, floor-shift by 30 and clamp to +/-65535
    function automatic logic signed [16:0] scale_coord(input logic signed [50:0] pv);
        logic signed [50:0] r;
        logic signed [20:0] q;
        logic signed [16:0] res;
        r = pv + 51'sd536870912;
        q = r[50:30];
        if (q > COORD_LIMIT)
            res = 17'sd65535;
        else if (q < -COORD_LIMIT)
            res = -17'sd65535;
        else
            res = q[16:0];
        return res;
    endfunction

    sps_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    sps_cordic u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cordic_start),
        .angle (beam_reg + QUARTER_TURN),
        .done  (cordic_done),
        .cos_v (cos_v),
        .sin_v (sin_v)
    );

    sps_mul u_mul (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (prod)
    );

    assign sample.ready = (state_reg == ST_IDLE);
    assign accept       = sample.valid && sample.ready;
    assign cordic_start = accept && (sample.range_mm != 16'd0);

    assign dx = 18'(px_reg) - 18'(last_x_reg);
    assign dy = 18'(py_reg) - 18'(last_y_reg);

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            ST_MX:
            begin
                mul_a = signed'({3'd0, range_reg});
                mul_b = cos_v;
            end
            ST_MY:
            begin
                mul_a = signed'({3'd0, range_reg});
                mul_b = sin_v;
            end
            ST_DX:
            begin
                mul_a = 19'(dx);
                mul_b = 32'(dx);
            end
            ST_DY:
            begin
                mul_a = 19'(dy);
                mul_b = 32'(dy);
            end
            ST_BD:
            begin
                mul_a = signed'({3'd0, cfg.break_mm});
                mul_b = signed'({16'd0, cfg.break_mm});
            end
            default: ;
        endcase
    end

    assign out_load = (state_reg == ST_OUT) && (!ov_reg || point.ready);
    assign seg_new  = (pv_reg && brk_reg && (seg_reg < 10'(SEG_LIMIT))) ?
                      seg_reg + 1'b1 : seg_reg;

    always_comb
    begin
        state_next  = state_reg;
        range_next  = range_reg;
        eos_next    = eos_reg;
        pv_next     = pv_reg;
        beam_next   = beam_reg;
        last_x_next = last_x_reg;
        last_y_next = last_y_reg;
        have_next   = have_reg;
        seg_next    = seg_reg;
        px_next     = px_reg;
        py_next     = py_reg;
        sq_next     = sq_reg;
        brk_next    = brk_reg;
        ov_next     = ov_reg && !point.ready;
        ox_next     = ox_reg;
        oy_next     = oy_reg;
        oseg_next   = oseg_reg;
        opv_next    = opv_reg;
        odone_next  = odone_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    range_next = sample.range_mm;
                    eos_next   = sample.end_of_scan;
                    pv_next    = (sample.range_mm != 16'd0);
                    brk_next   = 1'b0;
                    if (sample.range_mm != 16'd0)
                        state_next = ST_ROT;
                    else if (sample.end_of_scan)
                        state_next = ST_OUT;
                    else
                        beam_next = beam_reg + cfg.angle_step;
                end
            end
            ST_ROT:
            begin
                if (cordic_done)
                    state_next = ST_MX;
            end
            ST_MX:
                state_next = ST_MY;
            ST_MY:
            begin
                px_next    = scale_coord(prod);
                state_next = ST_DX;
            end
            ST_DX:
            begin
                py_next    = scale_coord(prod);
                state_next = ST_DY;
            end
            ST_DY:
            begin
                sq_next    = {1'b0, prod[34:0]};
                state_next = ST_BD;
            end
            ST_BD:
            begin
                sq_next    = sq_reg + {1'b0, prod[34:0]};
                state_next = ST_CMP;
            end
            ST_CMP:
            begin
                brk_next   = have_reg && (sq_reg >= {4'd0, prod[31:0]});
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (out_load)
                begin
                    ov_next    = 1'b1;
                    ox_next    = pv_reg ? px_reg : '0;
                    oy_next    = pv_reg ? py_reg : '0;
                    oseg_next  = seg_new;
                    opv_next   = pv_reg;
                    odone_next = eos_reg;
                    if (eos_reg)
                    begin
                        seg_next    = '0;
                        last_x_next = '0;
                        last_y_next = '0;
                        have_next   = 1'b0;
                        beam_next   = cfg.angle_start;
                    end
                    else
                    begin
                        beam_next = beam_reg + cfg.angle_step;
                        if (pv_reg)
                        begin
                            seg_next    = seg_new;
                            last_x_next = px_reg;
                            last_y_next = py_reg;
                            have_next   = 1'b1;
                        end
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase

        // writing angle_start restarts the angle count
        if (cfg.beam_load)
            beam_next = cfg.beam_value;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            beam_reg   <= '0;
            last_x_reg <= '0;
            last_y_reg <= '0;
            have_reg   <= 1'b0;
            seg_reg    <= '0;
            ov_reg     <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            beam_reg   <= beam_next;
            last_x_reg <= last_x_next;
            last_y_reg <= last_y_next;
            have_reg   <= have_next;
            seg_reg    <= seg_next;
            ov_reg     <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        range_reg <= range_next;
        eos_reg   <= eos_next;
        pv_reg    <= pv_next;
        px_reg    <= px_next;
        py_reg    <= py_next;
        sq_reg    <= sq_next;
        brk_reg   <= brk_next;
        ox_reg    <= ox_next;
        oy_reg    <= oy_next;
        oseg_reg  <= oseg_next;
        opv_reg   <= opv_next;
        odone_reg <= odone_next;
    end

    assign point.valid       = ov_reg;
    assign point.point_x     = ox_reg;
    assign point.point_y     = oy_reg;
    assign point.segment_id  = oseg_reg;
    assign point.point_valid = opv_reg;
    assign point.scan_done   = odone_reg;

    a_seg_limit: assert property (@(posedge clk) disable iff (!rst_n)
        ov_reg |-> (oseg_reg <= 10'(SEG_LIMIT)))
        else $error("segment number beyond limit");

    a_marker: assert property (@(posedge clk) disable iff (!rst_n)
        (ov_reg && !opv_reg) |-> (odone_reg && ox_reg == '0 && oy_reg == '0))
        else $error("bare marker malformed");

    a_scan_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && eos_reg && !cfg.beam_load) |=>
            (seg_reg == '0 && !have_reg && beam_reg == cfg.angle_start))
        else $error("scan state not cleared at end of scan");

    a_coord_range: assert property (@(posedge clk) disable iff (!rst_n)
        ov_reg |-> (ox_reg != 17'h10000 && oy_reg != 17'h10000))
        else $error("coordinate outside clamp");

endmodule
